### design/ptst_pkg.sv
// Shared constants, types and helpers for the port traffic statistics table.
package ptst_pkg;

  // Table geometry
  localparam int unsigned TABLE_ENTRIES = 16;
  localparam int unsigned COUNTER_BITS  = 32;
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

  // Request kinds
  localparam logic [2:0] KIND_RECORD = 3'd0;
  localparam logic [2:0] KIND_GET    = 3'd1;
  localparam logic [2:0] KIND_NEXT   = 3'd2;
  localparam logic [2:0] KIND_RANGE  = 3'd3;
  localparam logic [2:0] KIND_GLOBAL = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  localparam logic [3:0]  UID_MASK  = 4'h0F;
  localparam logic [4:0]  RANGE_MAX = 5'd31;

  localparam int unsigned IN_TDATA_W  = 152;
  localparam int unsigned IN_TUSER_W  = 3;
  localparam int unsigned OUT_TDATA_W = 192;
  localparam int unsigned OUT_TUSER_W = 2;

  typedef logic [COUNTER_BITS-1:0] cnt_t;
  typedef cnt_t [3:0]              cnt_row_t;

  // Input payload, lowest field in the lowest bits
  typedef struct packed {
    logic [5:0]  pad;
    logic [1:0]  action;
    logic [15:0] port_number;
    logic [63:0] addr_low;
    logic [63:0] addr_high;
  } in_data_t;

  // Result payload, lowest field in the lowest bits
  typedef struct packed {
    logic [6:0]  pad;
    logic [4:0]  active_ports;
    logic [15:0] last_active_port;
    logic [15:0] first_active_port;
    logic [31:0] out_ok;
    logic [31:0] out_rejected;
    logic [31:0] in_ok;
    logic [31:0] in_rejected;
    logic [3:0]  found_uid;
    logic [15:0] found_port;
  } out_data_t;

  // Controller -> datapath
  typedef struct packed {
    logic start;
    logic scan;
    logic finish;
    logic load_out;
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic scan_done;
  } dp_sts_t;

  function automatic logic [31:0] to_out32(input cnt_t v);
    logic [63:0] w;
    w = 64'(v);
    return w[31:0];
  endfunction

endpackage

### design/ptst_ctrl.sv
// Sequencing state machine for the port traffic statistics table.
module ptst_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  input  ptst_pkg::dp_sts_t sts_i,
  output ptst_pkg::dp_cmd_t cmd_o
);
  import ptst_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_FINISH = 4'b0100,
    ST_RESULT = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    s_ready_o   = 1'b0;
    out_valid_d = out_valid_q && !m_ready_i;
    case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_RESULT;
      end
      ST_RESULT: begin
        // wait for the output register to free up
        if (!out_valid_q || m_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_valid_o = out_valid_q;

endmodule

### design/ptst_dp.sv
// Datapath: entry table, scan evaluation, counter update and result register.
module ptst_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [ptst_pkg::IN_TDATA_W-1:0]      s_tdata_i,
  input  logic [ptst_pkg::IN_TUSER_W-1:0]      s_tuser_i,
  input  ptst_pkg::dp_cmd_t                    cmd_i,
  output ptst_pkg::dp_sts_t                    sts_o,
  output logic [ptst_pkg::OUT_TDATA_W-1:0]     m_tdata_o,
  output logic [ptst_pkg::OUT_TUSER_W-1:0]     m_tuser_o
);
  import ptst_pkg::*;

  in_data_t in_data;
  assign in_data = in_data_t'(s_tdata_i);

  // Entry storage
  logic [63:0] mem_hi   [TABLE_ENTRIES];
  logic [63:0] mem_lo   [TABLE_ENTRIES];
  logic [15:0] mem_port [TABLE_ENTRIES];
  logic [3:0]  mem_uid  [TABLE_ENTRIES];
  cnt_row_t    mem_cnt  [TABLE_ENTRIES];

  // Latched request
  logic [2:0]  req_kind_q;
  logic [63:0] req_hi_q, req_lo_q;
  logic [15:0] req_port_q;
  logic [1:0]  req_act_q;

  // Scan and read registers
  logic [CNT_W-1:0] idx_q, used_q;
  logic             rd_valid_q;
  logic [IDX_W-1:0] rd_idx_q;
  logic [63:0]      rd_hi_q, rd_lo_q;
  logic [15:0]      rd_port_q;
  logic [3:0]       rd_uid_q;
  cnt_row_t         rd_cnt_q;

  // Selected entry and range accumulators
  logic             hit_q, sel_q;
  logic [IDX_W-1:0] sel_idx_q;
  logic [15:0]      row_port_q;
  logic [3:0]       row_uid_q;
  cnt_row_t         row_cnt_q;
  logic [4:0]       n_q;
  logic [15:0]      first_q, last_q;

  cnt_row_t glb_q;

  out_data_t        out_q;
  logic [1:0]       status_q;

  // Result assembly
  out_data_t  out_d;
  logic [1:0] status_d;
  cnt_row_t   src;

  logic scan_done, rd_en;
  logic addr_eq, primary, capture, take_hit, is_next, room;
  logic append;
  cnt_row_t bump_row;

  assign scan_done       = (idx_q == used_q);
  assign sts_o.scan_done = scan_done;
  assign rd_en           = cmd_i.scan && !scan_done;

  assign addr_eq  = rd_valid_q && (rd_hi_q == req_hi_q) && (rd_lo_q == req_lo_q);
  assign primary  = addr_eq && ((req_port_q == 16'd0) || (rd_port_q == req_port_q));
  assign is_next  = (req_kind_q == KIND_NEXT);
  assign take_hit = !hit_q && primary;
  // get next: first same-address entry after the primary match
  assign capture  = is_next ? (hit_q && !sel_q && addr_eq)
                            : (((req_kind_q == KIND_RECORD) || (req_kind_q == KIND_GET))
                               && !sel_q && primary);

  assign room   = (used_q < CNT_W'(TABLE_ENTRIES));
  assign append = cmd_i.finish && (req_kind_q == KIND_RECORD) && !sel_q && room;

  always_comb begin
    bump_row            = sel_q ? row_cnt_q : '0;
    bump_row[req_act_q] = bump_row[req_act_q] + cnt_t'(1);
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      used_q     <= '0;
      rd_valid_q <= 1'b0;
      hit_q      <= 1'b0;
      sel_q      <= 1'b0;
      n_q        <= '0;
      glb_q      <= '0;
    end else begin
      rd_valid_q <= rd_en;
      if (cmd_i.start) begin
        idx_q <= '0;
        hit_q <= 1'b0;
        sel_q <= 1'b0;
        n_q   <= '0;
      end else begin
        if (rd_en) begin
          idx_q <= idx_q + CNT_W'(1);
        end
        if (take_hit) begin
          hit_q <= 1'b1;
        end
        if (capture || append) begin
          sel_q <= 1'b1;
        end
        if (addr_eq && (n_q != RANGE_MAX)) begin
          n_q <= n_q + 5'd1;
        end
      end
      if (append) begin
        used_q <= used_q + CNT_W'(1);
      end
      if (cmd_i.finish && (req_kind_q == KIND_RECORD)) begin
        glb_q[req_act_q] <= glb_q[req_act_q] + cnt_t'(1);
      end
    end
  end

  // Memories and payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      req_kind_q <= s_tuser_i;
      req_hi_q   <= in_data.addr_high;
      req_lo_q   <= in_data.addr_low;
      req_port_q <= in_data.port_number;
      req_act_q  <= in_data.action;
    end
    if (rd_en) begin
      rd_idx_q  <= idx_q[IDX_W-1:0];
      rd_hi_q   <= mem_hi[idx_q[IDX_W-1:0]];
      rd_lo_q   <= mem_lo[idx_q[IDX_W-1:0]];
      rd_port_q <= mem_port[idx_q[IDX_W-1:0]];
      rd_uid_q  <= mem_uid[idx_q[IDX_W-1:0]];
      rd_cnt_q  <= mem_cnt[idx_q[IDX_W-1:0]];
    end
    if (capture && !cmd_i.start) begin
      sel_idx_q  <= rd_idx_q;
      row_port_q <= rd_port_q;
      row_uid_q  <= rd_uid_q;
      row_cnt_q  <= rd_cnt_q;
    end
    if (addr_eq && !cmd_i.start) begin
      if (n_q == 5'd0) begin
        first_q <= rd_port_q;
        last_q  <= rd_port_q;
      end else if (rd_port_q < first_q) begin
        first_q <= rd_port_q;
      end else if (rd_port_q > last_q) begin
        last_q <= rd_port_q;
      end
    end
    if (cmd_i.finish && (req_kind_q == KIND_RECORD)) begin
      if (sel_q) begin
        mem_cnt[sel_idx_q] <= bump_row;
        row_cnt_q          <= bump_row;
      end else if (room) begin
        mem_hi[used_q[IDX_W-1:0]]   <= req_hi_q;
        mem_lo[used_q[IDX_W-1:0]]   <= req_lo_q;
        mem_port[used_q[IDX_W-1:0]] <= req_port_q;
        mem_uid[used_q[IDX_W-1:0]]  <= req_port_q[3:0] & UID_MASK;
        mem_cnt[used_q[IDX_W-1:0]]  <= bump_row;
        row_port_q                  <= req_port_q;
        row_uid_q                   <= req_port_q[3:0] & UID_MASK;
        row_cnt_q                   <= bump_row;
      end
    end
    if (cmd_i.load_out) begin
      out_q    <= out_d;
      status_q <= status_d;
    end
  end

  always_comb begin
    src      = (req_kind_q == KIND_GLOBAL) ? glb_q : row_cnt_q;
    out_d    = '0;
    status_d = ST_NOT_FOUND;
    case (req_kind_q)
      KIND_RECORD, KIND_GET, KIND_NEXT: begin
        if (sel_q) begin
          status_d           = ST_OK;
          out_d.found_port   = row_port_q;
          out_d.found_uid    = row_uid_q;
          out_d.in_rejected  = to_out32(cnt_t'(src[0] - src[1]));
          out_d.in_ok        = to_out32(src[1]);
          out_d.out_rejected = to_out32(cnt_t'(src[2] - src[3]));
          out_d.out_ok       = to_out32(src[3]);
        end else if (req_kind_q == KIND_RECORD) begin
          status_d = ST_FULL;
        end
      end
      KIND_RANGE: begin
        status_d                = ST_OK;
        out_d.active_ports      = n_q;
        out_d.first_active_port = (n_q == 5'd0) ? 16'd0 : first_q;
        out_d.last_active_port  = (n_q == 5'd0) ? 16'd0 : last_q;
      end
      KIND_GLOBAL: begin
        status_d           = ST_OK;
        out_d.in_rejected  = to_out32(cnt_t'(src[0] - src[1]));
        out_d.in_ok        = to_out32(src[1]);
        out_d.out_rejected = to_out32(cnt_t'(src[2] - src[3]));
        out_d.out_ok       = to_out32(src[3]);
      end
      default: begin
        status_d = ST_NOT_FOUND;
      end
    endcase
  end

  assign m_tdata_o = OUT_TDATA_W'(out_q);
  assign m_tuser_o = status_q;

endmodule

### design/port_traffic_stats_table_unit.sv
// Top level of the port traffic statistics table.
// Usage:
//   Requests arrive on the s_axis channel: tuser carries the request kind
//   (record, get, get next, range, global counts), tdata the 128-bit device
//   address, the UDP port and the action. Each request yields exactly one
//   result transaction on the m_axis channel: tuser carries the status,
//   tdata the entry port/id, the four counts and the port range fields.
// Sequencing:
//   One request is worked at a time. After acceptance the used entries are
//   scanned one entry per cycle through the single read port of the entry
//   memory, then the counters are updated and the result is loaded; the
//   next request is accepted in the cycle after the result is loaded.
// Reset:
//   The entry count and the global counters clear; entry contents are not
//   cleared and are only read below the entry count.
// Back-pressure:
//   The result sits in an output register. A new request may be accepted
//   and scanned while it waits; the block then holds before loading the
//   next result until the pending one has been taken.
module port_traffic_stats_table_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // addr_high [63:0], addr_low [127:64], port_number [143:128],
  // action [145:144], zero pad [151:146]
  input  logic [ptst_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  // kind [2:0]
  input  logic [ptst_pkg::IN_TUSER_W-1:0]     s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // found_port [15:0], found_uid [19:16], in_rejected [51:20],
  // in_ok [83:52], out_rejected [115:84], out_ok [147:116],
  // first_active_port [163:148], last_active_port [179:164],
  // active_ports [184:180], zero pad [191:185]
  output logic [ptst_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  // status [1:0]
  output logic [ptst_pkg::OUT_TUSER_W-1:0]    m_axis_tuser_o
);
  import ptst_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer: accept, scan, update, load result
  ptst_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // Table storage, match logic, counters and the output register
  ptst_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tdata_i (s_axis_tdata_i),
    .s_tuser_i (s_axis_tuser_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .m_tdata_o (m_axis_tdata_o),
    .m_tuser_o (m_axis_tuser_o)
  );

endmodule

### design/ptst_chk.sv
// Port-level checks for the port traffic statistics table.
module ptst_chk (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid_i,
  input logic                             s_axis_tready_o,
  input logic [ptst_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  input logic [ptst_pkg::IN_TUSER_W-1:0]  s_axis_tuser_i,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [ptst_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic [ptst_pkg::OUT_TUSER_W-1:0] m_axis_tuser_o
);
  import ptst_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // one request in flight: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("request accepted while another is in flight");

  // failed lookups carry an all-zero payload
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o != ST_OK) |-> (m_axis_tdata_o == '0))
    else $error("non-zero payload on failed request");

  // status code range
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o == ST_OK) || (m_axis_tuser_o == ST_NOT_FOUND) ||
                        (m_axis_tuser_o == ST_FULL))
    else $error("bad status code");

endmodule

bind port_traffic_stats_table_unit ptst_chk u_ptst_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

### sim/port_traffic_stats_table_unit_checker.sv
// Channel monitor, table predictor and result comparison for the stats table.
`timescale 1ns / 100ps

module port_traffic_stats_table_unit_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             req_tvalid_i,
  input  logic                             req_tready_i,
  input  logic [ptst_pkg::IN_TDATA_W-1:0]  req_tdata_i,
  input  logic [ptst_pkg::IN_TUSER_W-1:0]  req_tuser_i,
  input  logic                             rsp_tvalid_i,
  input  logic                             rsp_tready_i,
  input  logic [ptst_pkg::OUT_TDATA_W-1:0] rsp_tdata_i,
  input  logic [ptst_pkg::OUT_TUSER_W-1:0] rsp_tuser_i,
  output int                               errors_o,
  output int                               pending_o
);
  import ptst_pkg::*;

  // counter slots, indexed by action
  localparam int unsigned ACT_IN     = 0;
  localparam int unsigned ACT_IN_OK  = 1;
  localparam int unsigned ACT_OUT    = 2;
  localparam int unsigned ACT_OUT_OK = 3;

  typedef struct packed {
    logic [1:0] status;
    out_data_t  data;
  } stats_result_t;

  stats_result_t stats_expected_q[$];

  logic [63:0] tbl_hi   [TABLE_ENTRIES];
  logic [63:0] tbl_lo   [TABLE_ENTRIES];
  logic [15:0] tbl_port [TABLE_ENTRIES];
  cnt_row_t    tbl_cnt  [TABLE_ENTRIES];
  int unsigned tbl_used;
  cnt_row_t    global_cnt;
  int          fail_count = 0;
  int          pending_cnt = 0;

  assign errors_o  = fail_count;
  assign pending_o = pending_cnt;

  function automatic bit same_addr(int i, logic [63:0] hi, logic [63:0] lo);
    return tbl_hi[i] == hi && tbl_lo[i] == lo;
  endfunction

  // lowest matching entry, port 0 is a wildcard; -1 if none
  function automatic int find_entry(logic [63:0] hi, logic [63:0] lo, logic [15:0] port);
    for (int i = 0; i < int'(tbl_used); i++) begin
      if (same_addr(i, hi, lo) && (port == 16'd0 || port == tbl_port[i])) return i;
    end
    return -1;
  endfunction

  function automatic out_data_t count_view(cnt_row_t c);
    out_data_t d;
    d = '0;
    d.in_rejected  = to_out32(c[ACT_IN] - c[ACT_IN_OK]);
    d.in_ok        = to_out32(c[ACT_IN_OK]);
    d.out_rejected = to_out32(c[ACT_OUT] - c[ACT_OUT_OK]);
    d.out_ok       = to_out32(c[ACT_OUT_OK]);
    return d;
  endfunction

  function automatic out_data_t entry_view(int i);
    out_data_t d;
    d = count_view(tbl_cnt[i]);
    d.found_port = tbl_port[i];
    d.found_uid  = tbl_port[i][3:0] & UID_MASK;
    return d;
  endfunction

  // updates the shadow table and returns the result this request must give
  function automatic stats_result_t apply_request(logic [2:0] kind, in_data_t d);
    stats_result_t r;
    int            idx;
    int            nxt;
    int unsigned   n;
    logic [15:0]   lo_port;
    logic [15:0]   hi_port;
    r = '0;
    r.status = ST_OK;
    case (kind)
      KIND_RECORD: begin
        idx = find_entry(d.addr_high, d.addr_low, d.port_number);
        if (idx < 0 && tbl_used < TABLE_ENTRIES) begin
          idx = tbl_used;
          tbl_hi[idx]   = d.addr_high;
          tbl_lo[idx]   = d.addr_low;
          tbl_port[idx] = d.port_number;
          tbl_cnt[idx]  = '0;
          tbl_used++;
        end
        global_cnt[d.action] = global_cnt[d.action] + 1'b1;
        if (idx >= 0) begin
          tbl_cnt[idx][d.action] = tbl_cnt[idx][d.action] + 1'b1;
          r.data = entry_view(idx);
        end else begin
          r.status = ST_FULL;
        end
      end
      KIND_GET, KIND_NEXT: begin
        idx = find_entry(d.addr_high, d.addr_low, d.port_number);
        if (kind == KIND_NEXT && idx >= 0) begin
          // search resumes after the matched entry
          nxt = -1;
          for (int j = idx + 1; j < int'(tbl_used); j++) begin
            if (same_addr(j, d.addr_high, d.addr_low)) begin
              nxt = j;
              break;
            end
          end
          idx = nxt;
        end
        if (idx >= 0) r.data = entry_view(idx);
        else r.status = ST_NOT_FOUND;
      end
      KIND_RANGE: begin
        n = 0;
        lo_port = '0;
        hi_port = '0;
        for (int i = 0; i < int'(tbl_used); i++) begin
          if (same_addr(i, d.addr_high, d.addr_low)) begin
            if (n == 0) begin
              lo_port = tbl_port[i];
              hi_port = tbl_port[i];
            end else if (tbl_port[i] < lo_port) begin
              lo_port = tbl_port[i];
            end else if (tbl_port[i] > hi_port) begin
              hi_port = tbl_port[i];
            end
            n++;
          end
        end
        r.data.first_active_port = lo_port;
        r.data.last_active_port  = hi_port;
        r.data.active_ports      = (n > RANGE_MAX) ? RANGE_MAX : 5'(n);
      end
      KIND_GLOBAL: begin
        r.data = count_view(global_cnt);
      end
      default: begin
        r.status = ST_NOT_FOUND;
      end
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_result(input logic [1:0] status, input out_data_t got);
    stats_result_t want;
    if (stats_expected_q.size() == 0) begin
      $error("result transaction with no request outstanding");
      fail_count++;
      return;
    end
    want = stats_expected_q.pop_front();
    check_field("status", want.status, status);
    check_field("found_port", want.data.found_port, got.found_port);
    check_field("found_uid", want.data.found_uid, got.found_uid);
    check_field("in_rejected", want.data.in_rejected, got.in_rejected);
    check_field("in_ok", want.data.in_ok, got.in_ok);
    check_field("out_rejected", want.data.out_rejected, got.out_rejected);
    check_field("out_ok", want.data.out_ok, got.out_ok);
    check_field("first_active_port", want.data.first_active_port, got.first_active_port);
    check_field("last_active_port", want.data.last_active_port, got.last_active_port);
    check_field("active_ports", want.data.active_ports, got.active_ports);
    check_field("pad", want.data.pad, got.pad);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      tbl_used   = 0;
      global_cnt = '0;
      stats_expected_q.delete();
    end else begin
      if (rsp_tvalid_i && rsp_tready_i) check_result(rsp_tuser_i, rsp_tdata_i);
      if (req_tvalid_i && req_tready_i) begin
        stats_expected_q.push_back(apply_request(req_tuser_i, req_tdata_i));
      end
    end
    pending_cnt = stats_expected_q.size();
  end

endmodule

### sim/port_traffic_stats_table_unit_tb.sv
// Stimulus, flow control and verdict for the port traffic statistics table.
`timescale 1ns / 100ps

module port_traffic_stats_table_unit_tb;
  import ptst_pkg::*;

  localparam logic [2:0] KIND_SPARE_5 = 3'd5;
  localparam logic [2:0] KIND_SPARE_6 = 3'd6;
  localparam logic [2:0] KIND_SPARE_7 = 3'd7;

  localparam logic [1:0] ACT_IN     = 2'd0;
  localparam logic [1:0] ACT_IN_OK  = 2'd1;
  localparam logic [1:0] ACT_OUT    = 2'd2;
  localparam logic [1:0] ACT_OUT_OK = 2'd3;

  localparam int RANDOM_ITEMS = 1225;
  localparam logic [63:0] ONES = '1;

  typedef struct packed {
    logic [1:0]  ai;
    logic [15:0] port;
  } stats_pair_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [IN_TUSER_W-1:0]  s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;
  int                     fail_total;
  int                     outstanding;

  bit                     calm = 1'b0;
  int                     stall_left = 0;
  logic [63:0]            pool_hi [4];
  logic [63:0]            pool_lo [4];
  logic [15:0]            pool_port [8];
  stats_pair_t            recorded_q[$];

  port_traffic_stats_table_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  port_traffic_stats_table_unit_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_tvalid_i (s_axis_tvalid),
    .req_tready_i (s_axis_tready),
    .req_tdata_i  (s_axis_tdata),
    .req_tuser_i  (s_axis_tuser),
    .rsp_tvalid_i (m_axis_tvalid),
    .rsp_tready_i (m_axis_tready),
    .rsp_tdata_i  (m_axis_tdata),
    .rsp_tuser_i  (m_axis_tuser),
    .errors_o     (fail_total),
    .pending_o    (outstanding)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Idle length: mostly none or short, now and then long; none in calm stretches.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Result side back-pressure, changed on the falling edge.
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  // One request transaction; entered and left at a falling edge.
  task automatic send_req(input logic [2:0] kind, input logic [63:0] hi, input logic [63:0] lo,
                          input logic [15:0] port, input logic [1:0] act);
    in_data_t d;
    int       gap;
    d = '0;
    d.addr_high   = hi;
    d.addr_low    = lo;
    d.port_number = port;
    d.action      = act;
    s_axis_tdata  <= d;
    s_axis_tuser  <= kind;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Mostly well-formed traffic over a small set of addresses and ports so the
  // table fills slowly and lookups hit; a slice of random noise on top.
  task automatic random_req();
    int          r;
    bit          noise;
    stats_pair_t p;
    logic [2:0]  kind;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [15:0] port;
    logic [1:0]  act;
    r   = $urandom_range(0, 99);
    act = 2'($urandom_range(0, 3));
    if (r < 40) kind = KIND_RECORD;
    else if (r < 55) kind = KIND_GET;
    else if (r < 70) kind = KIND_NEXT;
    else if (r < 82) kind = KIND_RANGE;
    else if (r < 92) kind = KIND_GLOBAL;
    else kind = KIND_SPARE_5 + 3'($urandom_range(0, 2));
    noise = (kind == KIND_RECORD) ? ($urandom_range(0, 99) < 3) : ($urandom_range(0, 99) < 15);
    if (noise) begin
      hi   = {$urandom, $urandom};
      lo   = {$urandom, $urandom};
      port = 16'($urandom);
    end else begin
      if (kind == KIND_RECORD) begin
        // new pair now and then, otherwise bump one seen before
        if (recorded_q.size() == 0 || $urandom_range(0, 19) == 0) begin
          p.ai   = 2'($urandom_range(0, 3));
          p.port = pool_port[$urandom_range(0, 7)];
          recorded_q.push_back(p);
        end else begin
          p = recorded_q[$urandom_range(0, recorded_q.size() - 1)];
        end
      end else begin
        r = $urandom_range(0, 2);
        if (r == 0 && recorded_q.size() != 0) begin
          p = recorded_q[$urandom_range(0, recorded_q.size() - 1)];
        end else begin
          p.ai   = 2'($urandom_range(0, 3));
          p.port = (r == 1) ? 16'd0 : pool_port[$urandom_range(0, 7)];
        end
      end
      hi   = pool_hi[p.ai];
      lo   = pool_lo[p.ai];
      port = p.port;
    end
    send_req(kind, hi, lo, port, act);
  endtask

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = KIND_RECORD;

    // address pool: pairs share one half so both halves must be compared
    pool_hi[0] = {$urandom, $urandom};
    pool_lo[0] = {$urandom, $urandom};
    pool_hi[1] = pool_hi[0];
    pool_lo[1] = {$urandom, $urandom};
    pool_hi[2] = {$urandom, $urandom};
    pool_lo[2] = pool_lo[0];
    pool_hi[3] = {$urandom, $urandom};
    pool_lo[3] = {$urandom, $urandom};
    pool_port[0] = 16'h0001;
    pool_port[1] = 16'hFFFF;
    pool_port[2] = 16'h8000;
    pool_port[3] = 16'h0010;
    pool_port[4] = 16'h7FFE;
    pool_port[5] = 16'($urandom);
    pool_port[6] = 16'($urandom);
    pool_port[7] = 16'h0000;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // empty table
    send_req(KIND_GLOBAL, '0, '0, 16'd0, ACT_IN);
    send_req(KIND_GET, '0, '0, 16'd0, ACT_IN);
    send_req(KIND_NEXT, '0, '0, 16'd0, ACT_IN);
    send_req(KIND_RANGE, '0, '0, 16'd0, ACT_IN);
    // appends, including a port-0 entry, then a wildcard hit on it
    send_req(KIND_RECORD, ONES, ONES, 16'hFFFF, ACT_OUT_OK);
    send_req(KIND_RECORD, '0, '0, 16'd0, ACT_IN);
    send_req(KIND_RECORD, '0, '0, 16'd5, ACT_IN_OK);
    send_req(KIND_RECORD, '0, '0, 16'd0, ACT_OUT);
    send_req(KIND_RECORD, '0, '0, 16'd5, ACT_OUT_OK);
    // addresses that differ from others in only one half
    send_req(KIND_RECORD, ONES, '0, 16'h1234, ACT_IN);
    send_req(KIND_RECORD, '0, ONES, 16'h8001, ACT_IN_OK);
    // lookups: exact, wildcard, next, next at the last entry, missing port
    send_req(KIND_GET, '0, '0, 16'd5, ACT_IN);
    send_req(KIND_GET, '0, '0, 16'd0, ACT_IN);
    send_req(KIND_NEXT, '0, '0, 16'd0, ACT_IN);
    send_req(KIND_NEXT, '0, '0, 16'd5, ACT_IN);
    send_req(KIND_GET, '0, '0, 16'd7, ACT_IN);
    send_req(KIND_RANGE, '0, '0, 16'd0, ACT_IN);
    send_req(KIND_RANGE, ONES, ONES, 16'd0, ACT_IN);
    send_req(KIND_GET, ONES, ONES, 16'd0, ACT_IN);
    // undefined kinds leave the table alone
    send_req(KIND_SPARE_5, ONES, ONES, 16'hFFFF, ACT_OUT_OK);
    send_req(KIND_SPARE_6, '0, '0, 16'd0, ACT_IN);
    send_req(KIND_SPARE_7, ONES, ONES, 16'hFFFF, ACT_OUT_OK);
    send_req(KIND_GLOBAL, ONES, ONES, 16'hFFFF, ACT_OUT_OK);

    // random part; the table runs full partway through
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = ((n / 100) % 4) == 3;
      random_req();
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;

    // drain, then give the block time to show any stray result
    while (outstanding != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_total == 0 && outstanding == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
